[sv/fcss_pkg.sv]
`timescale 1ns / 1ps

package fcss_pkg;

  localparam int ACTION_W   = 2;
  localparam int TEMP_W     = 16;
  localparam int SPEED_W    = 7;
  localparam int PWM_W      = 9;
  localparam int POINT_W    = 23;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;
  localparam int LEN_W      = 3;

  localparam int NUM_POINT_REGS = 6;

  localparam logic [CFG_IDX_W-1:0] REG_CURVE_LENGTH = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_SELECT = 3'd7;

  localparam logic [ACTION_W-1:0] ACT_AUTO = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOW  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_HIGH = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_FULL = 2'd3;

  localparam logic [SPEED_W-1:0] FULL_SPEED = 7'd100;
  localparam logic [PWM_W-1:0]   TOP_FAST   = 9'd320;
  localparam logic [PWM_W-1:0]   TOP_ANALOG = 9'd255;

  localparam int DIV_NUM_W = 24;
  localparam int DIV_DEN_W = 17;
  localparam int DIV_Q_W   = 9;

  // Dividing a product of at most 32000 by 100 is exact as a multiply by
  // 5243 followed by a right shift of 19.
  localparam int          SCALE_IN_W   = 15;
  localparam int          SCALE_PROD_W = 28;
  localparam int          PCT_RECIP_SH = 19;
  localparam logic [12:0] PCT_RECIP    = 13'd5243;

  localparam int MUL_A_W = 10;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = 28;

  typedef struct packed {
    logic [ACTION_W-1:0]      action;
    logic signed [TEMP_W-1:0] temperature;
  } in_req_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed_percent;
    logic [PWM_W-1:0]   pwm_compare;
  } out_req_t;

  typedef struct packed {
    logic [LEN_W-1:0] used_len;
    logic             scale_sel;
  } cfg_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SELECT,
    ST_MUL_BASE,
    ST_MUL_SLOPE,
    ST_DIV_INTERP_GO,
    ST_DIV_INTERP_WAIT,
    ST_MUL_SCALE,
    ST_SCALE_RECIP,
    ST_DONE
  } state_t;

  function automatic logic [SPEED_W-1:0] point_speed(input logic [POINT_W-1:0] p);
    logic [SPEED_W-1:0] s;
    s = p[22:16];
    return (s > FULL_SPEED) ? FULL_SPEED : s;
  endfunction

  function automatic logic signed [TEMP_W-1:0] point_temp(input logic [POINT_W-1:0] p);
    return $signed(p[TEMP_W-1:0]);
  endfunction

endpackage

[sv/fan_curve_speed_select.sv]
`timescale 1ns / 1ps

// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid / in_ready    | in_data: action, temperature
// out     | output    | out_valid / out_ready  | out_data: speed_percent, pwm_compare
// cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A request is scanned over the curve one point per cycle. An interpolating request then
// uses the shared multiplier twice and the nine-step restoring divider once, which
// sets the rate. The duty is scaled with the same multiplier and a reciprocal multiply.
// in_ready stays low from acceptance until the result is loaded into the output register.
// Reset is synchronous and clears the control state, the output valid and the configuration.
// A stalled result holds in the output register and the next request waits for it.

module fan_curve_speed_select #(
  parameter int MAX_CURVE_POINTS = 6
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  fcss_pkg::in_req_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output fcss_pkg::out_req_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fcss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fcss_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fcss_pkg::*;

  localparam int PT_IDX_W = $clog2(MAX_CURVE_POINTS);

  logic [MAX_CURVE_POINTS-1:0][POINT_W-1:0] points;
  cfg_stat_t cfg_stat;

  state_t state_r, state_nxt;

  logic [ACTION_W-1:0]      action_r, action_nxt;
  logic signed [TEMP_W-1:0] temp_r, temp_nxt;
  logic [LEN_W-1:0]         cnt_r, cnt_nxt;
  logic                     have_start_r, have_start_nxt;
  logic                     have_end_r, have_end_nxt;
  logic [SPEED_W-1:0]       s0_r, s0_nxt;
  logic [SPEED_W-1:0]       s1_r, s1_nxt;
  logic signed [TEMP_W-1:0] t0_r, t0_nxt;
  logic signed [TEMP_W-1:0] t1_r, t1_nxt;
  logic [SPEED_W-1:0]       lo_r, lo_nxt;
  logic [SPEED_W-1:0]       hi_r, hi_nxt;
  logic [SPEED_W-1:0]       speed_r, speed_nxt;
  logic [PWM_W-1:0]         pwm_r, pwm_nxt;
  logic signed [MUL_P_W-1:0] prod_r, prod_nxt;
  logic [DIV_NUM_W-1:0]     num_r, num_nxt;
  logic [DIV_DEN_W-1:0]     den_r, den_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_req_t                 out_data_r, out_data_nxt;

  logic [POINT_W-1:0]        pt;
  logic [SPEED_W-1:0]        pt_speed;
  logic signed [TEMP_W-1:0]  pt_temp;
  logic                      scan_last;
  logic signed [MUL_B_W-1:0] den_diff;
  logic signed [MUL_B_W-1:0] dt_diff;
  logic signed [MUL_A_W-1:0] slope_diff;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic signed [MUL_P_W-1:0] num_sum;
  logic [PWM_W-1:0]          top;
  logic [SCALE_PROD_W-1:0]   scale_prod;

  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_dividend;
  logic [DIV_DEN_W-1:0] div_divisor;
  logic [DIV_Q_W-1:0]   div_q;
  div_stat_t            div_stat;
  logic                 out_load;

  fcss_cfg_regs #(
    .MAX_CURVE_POINTS (MAX_CURVE_POINTS)
  ) u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .points   (points),
    .stat     (cfg_stat)
  );

  fcss_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .stat     (div_stat)
  );

  assign cfg_ready = 1'b1;

  assign pt        = points[cnt_r[PT_IDX_W-1:0]];
  assign pt_speed  = point_speed(pt);
  assign pt_temp   = point_temp(pt);
  assign scan_last = (cnt_r == (cfg_stat.used_len - 1'b1));

  assign den_diff   = {{2{t1_r[TEMP_W-1]}}, t1_r} - {{2{t0_r[TEMP_W-1]}}, t0_r};
  assign dt_diff    = {{2{temp_r[TEMP_W-1]}}, temp_r} - {{2{t0_r[TEMP_W-1]}}, t0_r};
  assign slope_diff = {3'b000, s1_r} - {3'b000, s0_r};
  assign top        = cfg_stat.scale_sel ? TOP_ANALOG : TOP_FAST;

  assign mul_p   = mul_a * mul_b;
  assign num_sum = prod_r + mul_p;

  assign scale_prod = SCALE_PROD_W'(prod_r[SCALE_IN_W-1:0]) * SCALE_PROD_W'(PCT_RECIP);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (cfg_stat.used_len == '0) ? ST_SELECT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_SELECT;
        end
      end
      ST_SELECT: begin
        if (action_r == ACT_AUTO && have_start_r && have_end_r) begin
          state_nxt = ST_MUL_BASE;
        end else begin
          state_nxt = ST_MUL_SCALE;
        end
      end
      ST_MUL_BASE:      state_nxt = ST_MUL_SLOPE;
      ST_MUL_SLOPE:     state_nxt = ST_DIV_INTERP_GO;
      ST_DIV_INTERP_GO: state_nxt = ST_DIV_INTERP_WAIT;
      ST_DIV_INTERP_WAIT: begin
        if (div_stat.done) begin
          state_nxt = ST_MUL_SCALE;
        end
      end
      ST_MUL_SCALE:     state_nxt = ST_SCALE_RECIP;
      ST_SCALE_RECIP:   state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    div_start    = 1'b0;
    div_dividend = num_r;
    div_divisor  = den_r;
    mul_a        = '0;
    mul_b        = '0;
    out_load     = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_MUL_BASE: begin
        mul_a = {3'b000, s0_r};
        mul_b = den_diff;
      end
      ST_MUL_SLOPE: begin
        mul_a = slope_diff;
        mul_b = dt_diff;
      end
      ST_DIV_INTERP_GO: div_start = 1'b1;
      ST_MUL_SCALE: begin
        mul_a = {3'b000, speed_r};
        mul_b = {9'b0, top};
      end
      ST_DONE: out_load = !out_valid_r || out_ready;
      default: in_ready = 1'b0;
    endcase
  end

  always_comb begin
    action_nxt     = action_r;
    temp_nxt       = temp_r;
    cnt_nxt        = cnt_r;
    have_start_nxt = have_start_r;
    have_end_nxt   = have_end_r;
    s0_nxt         = s0_r;
    s1_nxt         = s1_r;
    t0_nxt         = t0_r;
    t1_nxt         = t1_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    speed_nxt      = speed_r;
    pwm_nxt        = pwm_r;
    prod_nxt       = prod_r;
    num_nxt        = num_r;
    den_nxt        = den_r;
    out_data_nxt   = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          action_nxt     = in_data.action;
          temp_nxt       = in_data.temperature;
          cnt_nxt        = '0;
          have_start_nxt = 1'b0;
          have_end_nxt   = 1'b0;
          lo_nxt         = FULL_SPEED;
          hi_nxt         = '0;
        end
      end
      ST_SCAN: begin
        if (pt_speed != '0 && pt_speed < lo_r) begin
          lo_nxt = pt_speed;
        end
        if (pt_speed < FULL_SPEED && pt_speed > hi_r) begin
          hi_nxt = pt_speed;
        end
        if (!have_end_r) begin
          if (pt_temp > temp_r) begin
            s1_nxt       = pt_speed;
            t1_nxt       = pt_temp;
            have_end_nxt = 1'b1;
          end else begin
            s0_nxt         = pt_speed;
            t0_nxt         = pt_temp;
            have_start_nxt = 1'b1;
          end
        end
        cnt_nxt = cnt_r + 1'b1;
      end
      ST_SELECT: begin
        case (action_r)
          ACT_AUTO: begin
            if (have_start_r) begin
              speed_nxt = s0_r;
            end else if (have_end_r) begin
              speed_nxt = s1_r;
            end else begin
              speed_nxt = '0;
            end
          end
          ACT_LOW:  speed_nxt = lo_r;
          ACT_HIGH: speed_nxt = hi_r;
          default:  speed_nxt = FULL_SPEED;
        endcase
      end
      ST_MUL_BASE: begin
        prod_nxt = mul_p;
        den_nxt  = den_diff[DIV_DEN_W-1:0];
      end
      ST_MUL_SLOPE: num_nxt = num_sum[DIV_NUM_W-1:0];
      ST_DIV_INTERP_WAIT: begin
        if (div_stat.done) begin
          speed_nxt = div_q[SPEED_W-1:0];
        end
      end
      ST_MUL_SCALE: prod_nxt = mul_p;
      ST_SCALE_RECIP: pwm_nxt = scale_prod[SCALE_PROD_W-1:PCT_RECIP_SH];
      ST_DONE: begin
        if (out_load) begin
          out_data_nxt.speed_percent = speed_r;
          out_data_nxt.pwm_compare   = pwm_r;
        end
      end
      default: cnt_nxt = cnt_r;
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    action_r     <= action_nxt;
    temp_r       <= temp_nxt;
    cnt_r        <= cnt_nxt;
    have_start_r <= have_start_nxt;
    have_end_r   <= have_end_nxt;
    s0_r         <= s0_nxt;
    s1_r         <= s1_nxt;
    t0_r         <= t0_nxt;
    t1_r         <= t1_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    speed_r      <= speed_nxt;
    pwm_r        <= pwm_nxt;
    prod_r       <= prod_nxt;
    num_r        <= num_nxt;
    den_r        <= den_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("block took a request and stayed ready");

  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIV_INTERP_WAIT))
    else $error("divider finished outside a wait state");

  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.speed_percent <= FULL_SPEED && out_data.pwm_compare <= TOP_FAST))
    else $error("result out of range");

  a_interp_bracket: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL_BASE) |-> (t0_r <= temp_r && temp_r < t1_r))
    else $error("interpolation points do not bracket the temperature");

endmodule

[sv/fcss_cfg_regs.sv]
`timescale 1ns / 1ps

module fcss_cfg_regs #(
  parameter int MAX_CURVE_POINTS = 6
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [fcss_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [fcss_pkg::CFG_DATA_W-1:0]     wr_data,
  output logic [MAX_CURVE_POINTS-1:0][fcss_pkg::POINT_W-1:0] points,
  output fcss_pkg::cfg_stat_t                 stat
);
  import fcss_pkg::*;

  logic [MAX_CURVE_POINTS-1:0][POINT_W-1:0] points_r;
  logic [LEN_W-1:0]                         len_r;
  logic                                     scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_r <= '0;
      len_r    <= '0;
      scale_r  <= 1'b0;
    end else if (wr_en) begin
      for (int k = 0; k < MAX_CURVE_POINTS; k++) begin
        if (wr_index == CFG_IDX_W'(k)) begin
          points_r[k] <= wr_data[POINT_W-1:0];
        end
      end
      if (wr_index == REG_CURVE_LENGTH) begin
        len_r <= wr_data[LEN_W-1:0];
      end
      if (wr_index == REG_SCALE_SELECT) begin
        scale_r <= wr_data[0];
      end
    end
  end

  assign points         = points_r;
  assign stat.used_len  = (len_r > LEN_W'(MAX_CURVE_POINTS)) ? LEN_W'(MAX_CURVE_POINTS) : len_r;
  assign stat.scale_sel = scale_r;

endmodule

[sv/fcss_div.sv]
`timescale 1ns / 1ps

module fcss_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [fcss_pkg::DIV_NUM_W-1:0]  dividend,
  input  logic [fcss_pkg::DIV_DEN_W-1:0]  divisor,
  output logic [fcss_pkg::DIV_Q_W-1:0]    quotient,
  output fcss_pkg::div_stat_t             stat
);
  import fcss_pkg::*;

  localparam int SH_W  = DIV_DEN_W + DIV_Q_W - 1;
  localparam int CNT_W = $clog2(DIV_Q_W);

  logic [DIV_NUM_W-1:0] rem_r, rem_nxt;
  logic [SH_W-1:0]      dsh_r, dsh_nxt;
  logic [DIV_Q_W-1:0]   q_r, q_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic                 ge;

  assign ge = ({{(SH_W-DIV_NUM_W){1'b0}}, rem_r} >= dsh_r);

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = dividend;
      dsh_nxt  = {divisor, {(DIV_Q_W-1){1'b0}}};
      q_nxt    = '0;
      cnt_nxt  = CNT_W'(DIV_Q_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - dsh_r[DIV_NUM_W-1:0];
      end
      q_nxt   = {q_r[DIV_Q_W-2:0], ge};
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
  end

  assign quotient  = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
  import fcss_pkg::*;

  localparam int PCT_FULL = int'(FULL_SPEED);
  localparam int TOP_320 = int'(TOP_FAST);
  localparam int TOP_255 = int'(TOP_ANALOG);
  localparam int MAX_PTS = 6;
  localparam int ITEMS_PER_CURVE = 68;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_BASE = '0;

  typedef struct packed {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    in_req_t               req;
    bit                    typed;
    out_req_t              duty;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_req_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [CFG_DATA_W-1:0] curve_points [NUM_POINT_REGS];
  logic [LEN_W-1:0] curve_len_reg;
  logic scale_is_analog;

  out_req_t duty_expect_q[$];
  stim_row_t stim_rows[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int duty_results_checked = 0;
  int random_curves = 0;

  fan_curve_speed_select u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic int curve_speed(int k);
    int s;
    s = curve_points[k][22:16];
    return (s > PCT_FULL) ? PCT_FULL : s;
  endfunction

  function automatic int curve_temp(int k);
    return $signed(curve_points[k][15:0]);
  endfunction

  function automatic int used_points();
    return (curve_len_reg > MAX_PTS) ? MAX_PTS : int'(curve_len_reg);
  endfunction

  function automatic out_req_t predict_fan_duty(in_req_t req);
    out_req_t res;
    int n, i, si, ei, spd, slo, shi, top;
    bit have_start, have_end;
    longint s0, s1, t0, t1, den, num, tval;
    n = used_points();
    slo = PCT_FULL;
    shi = 0;
    si = 0;
    ei = 0;
    have_start = 1'b0;
    have_end = 1'b0;
    tval = $signed(req.temperature);
    for (i = 0; i < n; i++) begin
      spd = curve_speed(i);
      if (spd > 0 && spd < slo) slo = spd;
      if (spd < PCT_FULL && spd > shi) shi = spd;
      if (!have_end) begin
        if (curve_temp(i) > tval) begin
          ei = i;
          have_end = 1'b1;
        end else begin
          si = i;
          have_start = 1'b1;
        end
      end
    end
    case (req.action)
      ACT_LOW: spd = slo;
      ACT_HIGH: spd = shi;
      ACT_FULL: spd = PCT_FULL;
      default: begin
        if (!have_start && !have_end) spd = 0;
        else if (!have_start) spd = curve_speed(ei);
        else if (!have_end) spd = curve_speed(si);
        else begin
          s0 = curve_speed(si);
          s1 = curve_speed(ei);
          t0 = curve_temp(si);
          t1 = curve_temp(ei);
          den = t1 - t0;
          if (den <= 0) spd = int'(s0);
          else begin
            num = s0 * den + (s1 - s0) * (tval - t0);
            if (num < 0) spd = 0;
            else begin
              num = num / den;
              spd = (num > PCT_FULL) ? PCT_FULL : int'(num);
            end
          end
        end
      end
    endcase
    top = scale_is_analog ? TOP_255 : TOP_320;
    res.speed_percent = SPEED_W'(spd);
    res.pwm_compare = PWM_W'(spd * top / PCT_FULL);
    return res;
  endfunction

  always @(posedge clk) begin
    out_req_t exp_duty;
    if (rst_n && out_valid && out_ready) begin
      if (duty_expect_q.size() == 0) begin
        $error("Result with no request pending: speed_percent %0d, pwm_compare %0d",
               out_data.speed_percent, out_data.pwm_compare);
        mismatch_count++;
      end else begin
        exp_duty = duty_expect_q.pop_front();
        duty_results_checked++;
        if (out_data.speed_percent !== exp_duty.speed_percent) begin
          $error("speed_percent: expected %0d, actual %0d",
                 exp_duty.speed_percent, out_data.speed_percent);
          mismatch_count++;
        end
        if (out_data.pwm_compare !== exp_duty.pwm_compare) begin
          $error("pwm_compare: expected %0d, actual %0d",
                 exp_duty.pwm_compare, out_data.pwm_compare);
          mismatch_count++;
        end
      end
    end
  end

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CURVE_LENGTH: curve_len_reg = val[LEN_W-1:0];
      REG_SCALE_SELECT: scale_is_analog = val[0];
      default: curve_points[idx] = val;
    endcase
  endtask

  task automatic push_request(input in_req_t req, input out_req_t exp_duty);
    cfg_valid <= 1'b0;
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    duty_expect_q.push_back(exp_duty);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (duty_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic add_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row = '0;
    row.is_write = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    stim_rows.push_back(row);
  endtask

  task automatic add_request(input logic [ACTION_W-1:0] act, input logic [TEMP_W-1:0] temp,
                             input bit typed, input logic [SPEED_W-1:0] spd,
                             input logic [PWM_W-1:0] pwm);
    stim_row_t row;
    row = '0;
    row.req.action = act;
    row.req.temperature = temp;
    row.typed = typed;
    row.duty.speed_percent = spd;
    row.duty.pwm_compare = pwm;
    stim_rows.push_back(row);
  endtask

  task automatic load_random_curve();
    int temps [NUM_POINT_REGS];
    int speeds [NUM_POINT_REGS];
    int base, span, i, j, swap, shape;
    shape = $urandom_range(0, 9);
    base = int'($urandom_range(0, 65535)) - 32768;
    span = $urandom_range(0, 1) ? int'($urandom_range(16, 3000)) : 65535;
    for (i = 0; i < NUM_POINT_REGS; i++) begin
      if (span == 65535) temps[i] = int'($urandom_range(0, 65535)) - 32768;
      else temps[i] = base + int'($urandom_range(0, span));
      if (temps[i] > 32767) temps[i] = 32767;
      speeds[i] = $urandom_range(0, (shape == 0) ? 127 : PCT_FULL);
    end
    if (shape != 1) begin
      for (i = 0; i < NUM_POINT_REGS - 1; i++) begin
        for (j = 0; j < NUM_POINT_REGS - 1 - i; j++) begin
          if (temps[j] > temps[j + 1]) begin
            swap = temps[j];
            temps[j] = temps[j + 1];
            temps[j + 1] = swap;
          end
          if (shape != 3 && speeds[j] > speeds[j + 1]) begin
            swap = speeds[j];
            speeds[j] = speeds[j + 1];
            speeds[j + 1] = swap;
          end
        end
      end
    end
    for (i = 0; i < NUM_POINT_REGS; i++) begin
      write_register(REG_POINT_BASE + CFG_IDX_W'(i), {speeds[i][6:0], temps[i][15:0]});
    end
    write_register(REG_CURVE_LENGTH,
                   CFG_DATA_W'((shape == 2) ? $urandom_range(0, 7) : $urandom_range(2, 6)));
    write_register(REG_SCALE_SELECT, CFG_DATA_W'($urandom_range(0, 1)));
    random_curves++;
  endtask

  function automatic in_req_t random_request();
    in_req_t r;
    int n, k, a, b, pick;
    n = used_points();
    if ($urandom_range(0, 99) < 60) r.action = ACT_AUTO;
    else begin
      case ($urandom_range(0, 2))
        0: r.action = ACT_LOW;
        1: r.action = ACT_HIGH;
        default: r.action = ACT_FULL;
      endcase
    end
    pick = $urandom_range(0, 9);
    if (n > 0 && pick < 4) begin
      k = $urandom_range(0, n - 1);
      r.temperature = TEMP_W'(curve_temp(k) + int'($urandom_range(0, 6)) - 3);
    end else if (n > 1 && pick < 7) begin
      k = $urandom_range(0, n - 2);
      a = curve_temp(k);
      b = curve_temp(k + 1);
      if (a <= b) r.temperature = TEMP_W'(a + int'($urandom_range(0, b - a)));
      else r.temperature = TEMP_W'(b + int'($urandom_range(0, a - b)));
    end else begin
      r.temperature = TEMP_W'($urandom);
    end
    return r;
  endfunction

  initial begin
    int p, c, j;
    int send_mix [4];
    int recv_mix [4];
    stim_row_t row;
    send_mix = '{0, 68, 0, 29};
    recv_mix = '{0, 0, 68, 29};
    for (j = 0; j < NUM_POINT_REGS; j++) curve_points[j] = '0;
    curve_len_reg = '0;
    scale_is_analog = 1'b0;

    add_request(ACT_AUTO, 16'h0000, 1'b1, 7'd0, 9'd0);
    add_request(ACT_AUTO, 16'h8000, 1'b1, 7'd0, 9'd0);
    add_request(ACT_LOW, 16'h7FFF, 1'b1, 7'd100, 9'd320);
    add_request(ACT_HIGH, 16'h0000, 1'b1, 7'd0, 9'd0);
    add_request(ACT_FULL, 16'h8000, 1'b1, 7'd100, 9'd320);
    add_write(REG_POINT_BASE + 3'd0, {7'd20, 16'hF600});
    add_write(REG_POINT_BASE + 3'd1, {7'd60, 16'h1E00});
    add_write(REG_POINT_BASE + 3'd2, {7'd100, 16'h4600});
    add_write(REG_CURVE_LENGTH, 23'd3);
    add_request(ACT_AUTO, 16'h8000, 1'b1, 7'd20, 9'd64);
    add_request(ACT_AUTO, 16'hF600, 1'b1, 7'd20, 9'd64);
    add_request(ACT_AUTO, 16'h7FFF, 1'b1, 7'd100, 9'd320);
    add_request(ACT_AUTO, 16'h0A00, 1'b1, 7'd40, 9'd128);
    add_request(ACT_AUTO, 16'h0A01, 1'b0, '0, '0);
    add_request(ACT_AUTO, 16'h1DFF, 1'b0, '0, '0);
    add_request(ACT_LOW, 16'h0000, 1'b1, 7'd20, 9'd64);
    add_request(ACT_HIGH, 16'h0000, 1'b1, 7'd60, 9'd192);
    add_request(ACT_FULL, 16'h0000, 1'b1, 7'd100, 9'd320);
    add_write(REG_SCALE_SELECT, 23'd1);
    add_request(ACT_FULL, 16'h0000, 1'b1, 7'd100, 9'd255);
    add_request(ACT_AUTO, 16'h0A00, 1'b1, 7'd40, 9'd102);
    add_request(ACT_LOW, 16'h0000, 1'b1, 7'd20, 9'd51);
    add_write(REG_POINT_BASE + 3'd3, {7'd127, 16'h8000});
    add_write(REG_POINT_BASE + 3'd4, {7'd0, 16'h7FFF});
    add_write(REG_POINT_BASE + 3'd5, {7'd5, 16'h0000});
    add_write(REG_CURVE_LENGTH, 23'd7);
    add_request(ACT_LOW, 16'h0000, 1'b0, '0, '0);
    add_request(ACT_HIGH, 16'h0000, 1'b0, '0, '0);
    add_request(ACT_AUTO, 16'h7FFF, 1'b0, '0, '0);
    add_request(ACT_AUTO, 16'h4000, 1'b0, '0, '0);
    add_request(ACT_AUTO, 16'h5000, 1'b0, '0, '0);
    add_write(REG_CURVE_LENGTH, 23'd1);
    add_request(ACT_AUTO, 16'h8000, 1'b1, 7'd20, 9'd51);
    add_request(ACT_AUTO, 16'h7FFF, 1'b1, 7'd20, 9'd51);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[j]) begin
      row = stim_rows[j];
      if (row.is_write) begin
        wait_for_results();
        write_register(row.reg_idx, row.reg_val);
      end else begin
        push_request(row.req, row.typed ? row.duty : predict_fan_duty(row.req));
      end
    end

    for (p = 0; p < 4; p++) begin
      for (c = 0; c < 2; c++) begin
        wait_for_results();
        send_idle_pct = send_mix[p];
        recv_stall_pct = recv_mix[p];
        load_random_curve();
        for (j = 0; j < ITEMS_PER_CURVE; j++) begin
          row.req = random_request();
          push_request(row.req, predict_fan_duty(row.req));
        end
      end
    end

    wait_for_results();
    recv_stall_pct = 0;
    repeat (40) @(posedge clk);
    $display("Checked %0d duty results from %0d directed rows and %0d random curves,",
             duty_results_checked, stim_rows.size(), random_curves);
    $display("under four mixes of sender gaps and receiver stalls.");
    if (mismatch_count == 0 && duty_expect_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("FAILURE");
    $finish;
  end

endmodule
